// ----- rtl/core/kuf_pkg.sv -----
package kuf_pkg;

  localparam int unsigned NODE_W    = 10;
  localparam int unsigned MAX_NODES = 1024;
  localparam int unsigned RANK_W    = 4;
  localparam int unsigned COST_W    = 16;
  localparam int unsigned TOTAL_W   = 32;
  localparam int unsigned PADDR_W   = 2;

  localparam logic [RANK_W-1:0]  RANK_MAX  = '1;
  localparam logic [PADDR_W-1:0] ADDR_NODE_COUNT = 2'd0;

  // One input edge
  typedef struct packed {
    logic [NODE_W-1:0]        node_a;
    logic [NODE_W-1:0]        node_b;
    logic signed [COST_W-1:0] edge_cost;
    logic                     last_edge;
  } kuf_item_t;

  // One result item
  typedef struct packed {
    logic                      accepted;
    logic [NODE_W-1:0]         out_node_a;
    logic [NODE_W-1:0]         out_node_b;
    logic signed [TOTAL_W-1:0] total_cost;
    logic                      tree_done;
    logic                      last_out;
  } kuf_result_t;

  // Forest entry: rank is meaningful only while parent is zero (a root)
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [NODE_W-1:0] parent;
  } kuf_entry_t;

  // Datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_FIND_START,
    DP_FIND_NEXT,
    DP_FIND_ROOT,
    DP_COMP_READ,
    DP_COMP_WRITE,
    DP_JOIN,
    DP_RANK_INC,
    DP_EMIT,
    DP_CLEAR
  } kuf_op_e;

  typedef struct packed {
    logic    load;
    kuf_op_e op;
    logic    side;
  } kuf_cmd_t;

  typedef struct packed {
    logic eligible;
    logic parent_zero;
    logic roots_differ;
    logic rank_inc;
    logic clr_last;
    logic last;
  } kuf_sts_t;

endpackage

// ----- rtl/core/kuf_ctrl.sv -----
module kuf_ctrl import kuf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  kuf_sts_t sts_i,
  output kuf_cmd_t cmd_o,
  output logic     busy_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_FIND,
    ST_COMP,
    ST_COMP_RD,
    ST_JOIN,
    ST_RANK,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   side_q, side_d;

  // Sequence one edge: check, walk A, compress A, walk B, compress B, join, report
  always_comb begin
    state_d    = state_q;
    side_d     = side_q;
    cmd_o.load = 1'b0;
    cmd_o.op   = DP_NOP;
    cmd_o.side = side_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.op = DP_CLEAR;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.eligible) begin
          cmd_o.op   = DP_FIND_START;
          cmd_o.side = 1'b0;
          side_d     = 1'b0;
          state_d    = ST_FIND;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_FIND: begin
        if (sts_i.parent_zero) begin
          cmd_o.op = DP_FIND_ROOT;
          state_d  = ST_COMP;
        end else begin
          cmd_o.op = DP_FIND_NEXT;
        end
      end
      ST_COMP: begin
        if (sts_i.parent_zero) begin
          if (!side_q) begin
            cmd_o.op   = DP_FIND_START;
            cmd_o.side = 1'b1;
            side_d     = 1'b1;
            state_d    = ST_FIND;
          end else begin
            state_d = ST_JOIN;
          end
        end else begin
          cmd_o.op = DP_COMP_WRITE;
          state_d  = ST_COMP_RD;
        end
      end
      ST_COMP_RD: begin
        cmd_o.op = DP_COMP_READ;
        state_d  = ST_COMP;
      end
      ST_JOIN: begin
        if (sts_i.roots_differ) begin
          cmd_o.op = DP_JOIN;
          state_d  = sts_i.rank_inc ? ST_RANK : ST_EMIT;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_RANK: begin
        cmd_o.op = DP_RANK_INC;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.op = DP_EMIT;
        state_d  = sts_i.last ? ST_CLEAR : ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Hold state; start with a clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      side_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      side_q  <= side_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ----- rtl/core/kuf_dpath.sv -----
module kuf_dpath import kuf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kuf_cmd_t          cmd_i,
  input  kuf_item_t         in_item_i,
  input  logic [NODE_W-1:0] node_count_i,
  output kuf_sts_t          sts_o,
  output kuf_result_t       result_o,
  output logic              result_valid_o
);

  kuf_entry_t                mem_q [MAX_NODES];
  kuf_entry_t                rdata_q;
  kuf_item_t                 item_q;
  logic [NODE_W-1:0]         cur_q;
  logic [NODE_W-1:0]         root_a_q, root_b_q;
  logic [RANK_W-1:0]         rank_a_q, rank_b_q;
  logic [NODE_W-1:0]         clr_q;
  logic [NODE_W-1:0]         count_q;
  logic signed [TOTAL_W-1:0] total_q;
  kuf_result_t               result_q;
  logic                      valid_q;
  logic                      joined_q;

  logic                      mem_we;
  logic [NODE_W-1:0]         mem_addr;
  kuf_entry_t                mem_wdata;
  logic [NODE_W-1:0]         side_node;
  logic [NODE_W-1:0]         side_root;
  logic                      tree_complete;
  logic                      a_ok, b_ok;
  logic signed [TOTAL_W:0]   sum;
  logic signed [TOTAL_W-1:0] sum_sat;

  assign side_node = cmd_i.side ? item_q.node_b : item_q.node_a;
  assign side_root = cmd_i.side ? root_b_q : root_a_q;

  // Tree is complete once node_count-1 edges are in
  assign tree_complete = (node_count_i == '0) || (count_q >= node_count_i - NODE_W'(1));
  assign a_ok = (item_q.node_a != '0) && (item_q.node_a <= node_count_i);
  assign b_ok = (item_q.node_b != '0) && (item_q.node_b <= node_count_i);

  assign sts_o.eligible     = !tree_complete && a_ok && b_ok;
  assign sts_o.parent_zero  = (rdata_q.parent == '0);
  assign sts_o.roots_differ = (root_a_q != root_b_q);
  assign sts_o.rank_inc     = (rank_a_q == rank_b_q) && (rank_b_q != RANK_MAX);
  assign sts_o.clr_last     = (clr_q == '1);
  assign sts_o.last         = item_q.last_edge;

  // Saturating add of the edge cost
  assign sum = {total_q[TOTAL_W-1], total_q} + (TOTAL_W+1)'(item_q.edge_cost);
  always_comb begin
    if (sum[TOTAL_W] != sum[TOTAL_W-1]) begin
      sum_sat = sum[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}} : {1'b0, {(TOTAL_W-1){1'b1}}};
    end else begin
      sum_sat = sum[TOTAL_W-1:0];
    end
  end

  // Select the forest port address and write data
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = cur_q;
    mem_wdata = '0;
    case (cmd_i.op)
      DP_FIND_START: mem_addr = side_node;
      DP_FIND_NEXT:  mem_addr = rdata_q.parent;
      DP_FIND_ROOT:  mem_addr = side_node;
      DP_COMP_READ:  mem_addr = cur_q;
      DP_COMP_WRITE: begin
        mem_we           = 1'b1;
        mem_addr         = cur_q;
        mem_wdata.parent = side_root;
      end
      DP_JOIN: begin
        mem_we = 1'b1;
        if (rank_a_q > rank_b_q) begin
          mem_addr         = root_b_q;
          mem_wdata.parent = root_a_q;
        end else begin
          mem_addr         = root_a_q;
          mem_wdata.parent = root_b_q;
        end
      end
      DP_RANK_INC: begin
        mem_we         = 1'b1;
        mem_addr       = root_b_q;
        mem_wdata.rank = rank_b_q + RANK_W'(1);
      end
      DP_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Single-port forest memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end else begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  // Walk registers and captured item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_item_i;
    case (cmd_i.op)
      DP_FIND_START: cur_q <= side_node;
      DP_FIND_NEXT:  cur_q <= rdata_q.parent;
      DP_FIND_ROOT: begin
        cur_q <= side_node;
        if (cmd_i.side) begin
          root_b_q <= cur_q;
          rank_b_q <= rdata_q.rank;
        end else begin
          root_a_q <= cur_q;
          rank_a_q <= rdata_q.rank;
        end
      end
      DP_COMP_WRITE: cur_q <= rdata_q.parent;
      DP_EMIT: begin
        result_q.accepted   <= joined_q;
        result_q.out_node_a <= item_q.node_a;
        result_q.out_node_b <= item_q.node_b;
        result_q.total_cost <= total_q;
        result_q.tree_done  <= tree_complete;
        result_q.last_out   <= item_q.last_edge;
      end
      default: cur_q <= cur_q;
    endcase
  end

  // Count, total, accept flag, clear sweep and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      count_q  <= '0;
      total_q  <= '0;
      valid_q  <= 1'b0;
      joined_q <= 1'b0;
    end else begin
      valid_q <= (cmd_i.op == DP_EMIT);
      if (cmd_i.load) joined_q <= 1'b0;
      case (cmd_i.op)
        DP_CLEAR: clr_q <= clr_q + NODE_W'(1);
        DP_JOIN: begin
          count_q  <= count_q + NODE_W'(1);
          total_q  <= sum_sat;
          joined_q <= 1'b1;
        end
        DP_EMIT: begin
          if (item_q.last_edge) begin
            count_q <= '0;
            total_q <= '0;
          end
        end
        default: clr_q <= clr_q;
      endcase
    end
  end

  // Drive the held result
  assign result_o       = result_q;
  assign result_valid_o = valid_q;

endmodule

// ----- rtl/core/kruskal_union_find_edge_filter_core.sv -----
// Kruskal edge filter over a disjoint-set forest of 1024 entries (union by rank,
// full path compression). Pulse start with an edge while busy is low; exactly
// one result follows on result_o, marked by result_valid_o for one cycle, and
// must be taken then since it cannot be stalled. A rejected edge (tree already
// complete or an endpoint out of range) goes from the check straight to its
// result. An edge that walks follows the links from endpoint A to its root,
// then compresses that path, writing the root into each entry and reading the
// next link in turn on the single-port forest memory; endpoint B follows, then
// the join and, when a rank grows, a rank step. After reset and after every
// edge marked last, a clearing pass over all 1024 entries holds busy high.
// Write node_count at address 0 only while busy is low and no result is due.
module kruskal_union_find_edge_filter_core import kuf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  kuf_item_t          in_item_i,
  output kuf_result_t        result_o,
  output logic               result_valid_o
);

  logic [NODE_W-1:0] node_count_q;
  kuf_cmd_t          cmd;
  kuf_sts_t          sts;
  logic              ctrl_busy;

  // Config register: node count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_W'(1);
    end else if (psel && penable && pwrite && (paddr == ADDR_NODE_COUNT)) begin
      node_count_q <= pwdata[NODE_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_NODE_COUNT) ? {{(32-NODE_W){1'b0}}, node_count_q} : '0;

  kuf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (ctrl_busy)
  );

  kuf_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .in_item_i      (in_item_i),
    .node_count_i   (node_count_q),
    .sts_o          (sts),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  assign busy = ctrl_busy;

endmodule
